/* rtl/fdco_pkg.sv */
`timescale 1ns / 1ps
package fdco_pkg;

	// number format
	localparam int FRAC_BITS = 32;
	localparam int WORD_W    = 64;
	localparam int PROD_W    = 2 * WORD_W;
	// sum of four full products, with sign and carry room
	localparam int SUM_W     = PROD_W + 2;
	// divisor is twice the norm sum
	localparam int DEN_W     = SUM_W + 1;
	// remainder must hold the divisor shifted by a full word
	localparam int REM_W     = DEN_W + WORD_W;
	// quotient bits below the saturation bit
	localparam int QUO_W     = WORD_W - 1;

	// action codes
	localparam logic [2:0] ACT_MUL           = 3'd0;
	localparam logic [2:0] ACT_MUL_CONJ      = 3'd1;
	localparam logic [2:0] ACT_SELF_NORM     = 3'd2;
	localparam logic [2:0] ACT_INV_NORM_SUM  = 3'd3;
	localparam logic [2:0] ACT_SCALE_BY_REAL = 3'd4;
	localparam logic [2:0] ACT_SUM_MUL_CONJ  = 3'd5;

	localparam logic signed [WORD_W-1:0] RES_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] RES_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct packed {
		logic [2:0]               action;
		logic signed [WORD_W-1:0] p_re;
		logic signed [WORD_W-1:0] p_im;
		logic signed [WORD_W-1:0] q_re;
		logic signed [WORD_W-1:0] q_im;
		logic signed [WORD_W-1:0] s_re;
		logic signed [WORD_W-1:0] s_im;
		logic signed [WORD_W-1:0] t_re;
		logic signed [WORD_W-1:0] t_im;
		logic                     last;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] res_re;
		logic signed [WORD_W-1:0] res_im;
		logic                     overflow;
		logic                     div_zero;
		logic                     last_out;
	} out_word_t;

	// control travelling with each word down the pipe
	typedef struct packed {
		logic       valid;
		logic [2:0] action;
		logic       last;
	} ctrl_t;

	// rounded result of the product actions, carried past the divider
	typedef struct packed {
		logic signed [WORD_W-1:0] re;
		logic signed [WORD_W-1:0] im;
		logic                     ovf;
	} side_t;

endpackage

/* rtl/fdco_mul.sv */
`timescale 1ns / 1ps
module fdco_mul
	import fdco_pkg::*;
(
	input  logic                      clk,
	input  logic signed [WORD_W-1:0]  a,
	input  logic signed [WORD_W-1:0]  b,
	output logic signed [PROD_W-1:0]  p
);

	localparam int HW = WORD_W / 2;

	logic signed [WORD_W-1:0] hh_s2;
	logic signed [WORD_W:0]   hl_s2;
	logic signed [WORD_W:0]   lh_s2;
	logic        [WORD_W-1:0] ll_s2;

	logic signed [WORD_W+1:0] mid_s3;
	logic signed [WORD_W-1:0] hh_s3;
	logic        [WORD_W-1:0] ll_s3;

	logic signed [PROD_W-1:0] prod_s4;

	// form the four half-word partial products
	always_ff @(posedge clk) begin
		hh_s2 <= $signed(a[WORD_W-1:HW]) * $signed(b[WORD_W-1:HW]);
		hl_s2 <= $signed(a[WORD_W-1:HW]) * $signed({1'b0, b[HW-1:0]});
		lh_s2 <= $signed({1'b0, a[HW-1:0]}) * $signed(b[WORD_W-1:HW]);
		ll_s2 <= a[HW-1:0] * b[HW-1:0];
	end

	// fold the cross terms
	always_ff @(posedge clk) begin
		mid_s3 <= $signed({hl_s2[WORD_W], hl_s2}) + $signed({lh_s2[WORD_W], lh_s2});
		hh_s3  <= hh_s2;
		ll_s3  <= ll_s2;
	end

	// place the cross terms between the outer ones
	always_ff @(posedge clk) begin
		prod_s4 <= $signed({hh_s3, ll_s3})
			+ $signed({{(PROD_W-WORD_W-2-HW){mid_s3[WORD_W+1]}}, mid_s3, {HW{1'b0}}});
	end

	assign p = prod_s4;

endmodule

/* rtl/fdco_recip.sv */
`timescale 1ns / 1ps
module fdco_recip
	import fdco_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl_in,
	input  logic [SUM_W-1:0]  n_in,
	input  side_t             side_in,
	output ctrl_t             ctrl_out,
	output side_t             side_out,
	output logic [QUO_W-1:0]  quot,
	output logic              quot_ovf,
	output logic              dz
);

	localparam logic [REM_W-1:0] NUM_ONE = REM_W'(1) << (3 * FRAC_BITS + 1);

	ctrl_t             ctrl_d0;
	side_t             side_d0;
	logic [REM_W-1:0]  num_d0;
	logic [DEN_W-1:0]  den_d0;
	logic              dz_d0;

	ctrl_t             ctrl_st [0:QUO_W];
	side_t             side_st [0:QUO_W];
	logic [REM_W-1:0]  r_st    [0:QUO_W];
	logic [DEN_W-1:0]  d_st    [0:QUO_W];
	logic [QUO_W-1:0]  q_st    [0:QUO_W];
	logic              ovf_st  [0:QUO_W];
	logic              dz_st   [0:QUO_W];

	logic [REM_W:0]    top_trial;

	// form numerator 2^(3F+1)+N and divisor 2N
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_d0 <= '0;
		end else begin
			ctrl_d0 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		side_d0 <= side_in;
		num_d0  <= REM_W'(n_in) + NUM_ONE;
		den_d0  <= {n_in, 1'b0};
		dz_d0   <= (n_in == '0);
	end

	// test whether the quotient reaches the saturation bit
	assign top_trial = {1'b0, num_d0} - {1'b0, (REM_W'(den_d0) << QUO_W)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_st[0] <= '0;
		end else begin
			ctrl_st[0] <= ctrl_d0;
		end
	end

	always_ff @(posedge clk) begin
		side_st[0] <= side_d0;
		r_st[0]    <= num_d0;
		d_st[0]    <= den_d0;
		q_st[0]    <= '0;
		ovf_st[0]  <= !top_trial[REM_W];
		dz_st[0]   <= dz_d0;
	end

	// one restoring step per stage, most significant quotient bit first
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int BIT = QUO_W - 1 - k;
		logic [REM_W:0] trial;

		assign trial = {1'b0, r_st[k]} - {1'b0, (REM_W'(d_st[k]) << BIT)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_st[k+1] <= '0;
			end else begin
				ctrl_st[k+1] <= ctrl_st[k];
			end
		end

		always_ff @(posedge clk) begin
			side_st[k+1] <= side_st[k];
			d_st[k+1]    <= d_st[k];
			ovf_st[k+1]  <= ovf_st[k];
			dz_st[k+1]   <= dz_st[k];
			if (trial[REM_W]) begin
				r_st[k+1] <= r_st[k];
				q_st[k+1] <= q_st[k];
			end else begin
				r_st[k+1] <= trial[REM_W-1:0];
				q_st[k+1] <= q_st[k] | (QUO_W'(1) << BIT);
			end
		end
	end

	assign ctrl_out = ctrl_st[QUO_W];
	assign side_out = side_st[QUO_W];
	assign quot     = q_st[QUO_W];
	assign quot_ovf = ovf_st[QUO_W];
	assign dz       = dz_st[QUO_W];

endmodule

/* rtl/fft_domain_complex_ops_unit.sv */
`timescale 1ns / 1ps
// Pointwise complex arithmetic on FFT-domain slots in signed fixed point.
// A word is taken whenever start is high; busy stays low, so one word may
// enter every cycle. Each result appears on result for one cycle with done
// high, in the order the words came in. The pipe holds seven stages of
// product and sum, two stages of divider set-up, one restoring step per
// quotient bit (63 stages) and the output register; every action runs the
// same length of pipe.
module fft_domain_complex_ops_unit
	import fdco_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  item,
	output logic      done,
	output out_word_t result
);

	localparam int LATENCY = 10 + QUO_W;
	localparam int TERMS   = 8;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

	logic signed [WORD_W-1:0] opa_c [TERMS];
	logic signed [WORD_W-1:0] opb_c [TERMS];
	logic [3:0]               sub_c;

	logic signed [WORD_W-1:0] opa_s1 [TERMS];
	logic signed [WORD_W-1:0] opb_s1 [TERMS];
	logic [3:0]               sub_s1, sub_s2, sub_s3, sub_s4;
	ctrl_t                    ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6, ctrl_s7;

	logic signed [PROD_W-1:0] prod_s4 [TERMS];

	logic signed [SUM_W-1:0]  ra_s5, rb_s5, ia_s5, ib_s5;
	logic signed [SUM_W-1:0]  re_s6, im_s6;
	logic signed [SUM_W-1:0]  re_s7, im_s7, n_s7;

	logic [WORD_W:0]          re_sat, im_sat;
	side_t                    side_c;

	ctrl_t                    ctrl_dv;
	side_t                    side_dv;
	logic [QUO_W-1:0]         quot_dv;
	logic                     qovf_dv, dz_dv;

	out_word_t                res_c, result_q;
	logic                     done_q;

	// drop the fraction and saturate to one word (the half for rounding up is added beforehand)
	function automatic logic [WORD_W:0] round_sat(input logic [SUM_W-1:0] x);
		logic [SUM_W-FRAC_BITS-WORD_W:0] hi;
		hi = x[SUM_W-1:FRAC_BITS+WORD_W-1];
		if ((&hi) || !(|hi)) begin
			return {1'b0, x[FRAC_BITS+WORD_W-1:FRAC_BITS]};
		end
		return {1'b1, (x[SUM_W-1] ? RES_MIN : RES_MAX)};
	endfunction

	assign busy = 1'b0;

	// route operands onto the eight product terms
	always_comb begin
		for (int k = 0; k < TERMS; k++) begin
			opa_c[k] = '0;
			opb_c[k] = '0;
		end
		sub_c = '0;
		case (item.action)
			ACT_MUL: begin
				opa_c[0] = item.p_re; opb_c[0] = item.q_re;
				opa_c[1] = item.p_im; opb_c[1] = item.q_im; sub_c[0] = 1'b1;
				opa_c[4] = item.p_re; opb_c[4] = item.q_im;
				opa_c[5] = item.p_im; opb_c[5] = item.q_re;
			end
			ACT_MUL_CONJ: begin
				opa_c[0] = item.p_re; opb_c[0] = item.q_re;
				opa_c[1] = item.p_im; opb_c[1] = item.q_im;
				opa_c[4] = item.p_im; opb_c[4] = item.q_re;
				opa_c[5] = item.p_re; opb_c[5] = item.q_im; sub_c[2] = 1'b1;
			end
			ACT_SELF_NORM: begin
				opa_c[0] = item.p_re; opb_c[0] = item.p_re;
				opa_c[1] = item.p_im; opb_c[1] = item.p_im;
			end
			ACT_INV_NORM_SUM: begin
				opa_c[0] = item.p_re; opb_c[0] = item.p_re;
				opa_c[1] = item.p_im; opb_c[1] = item.p_im;
				opa_c[4] = item.q_re; opb_c[4] = item.q_re;
				opa_c[5] = item.q_im; opb_c[5] = item.q_im;
			end
			ACT_SCALE_BY_REAL: begin
				opa_c[0] = item.p_re; opb_c[0] = item.q_re;
				opa_c[4] = item.p_im; opb_c[4] = item.q_re;
			end
			ACT_SUM_MUL_CONJ: begin
				opa_c[0] = item.p_re; opb_c[0] = item.s_re;
				opa_c[1] = item.p_im; opb_c[1] = item.s_im;
				opa_c[2] = item.q_re; opb_c[2] = item.t_re;
				opa_c[3] = item.q_im; opb_c[3] = item.t_im;
				opa_c[4] = item.p_im; opb_c[4] = item.s_re;
				opa_c[5] = item.p_re; opb_c[5] = item.s_im; sub_c[2] = 1'b1;
				opa_c[6] = item.q_im; opb_c[6] = item.t_re;
				opa_c[7] = item.q_re; opb_c[7] = item.t_im; sub_c[3] = 1'b1;
			end
			default: begin
				sub_c = '0;
			end
		endcase
	end

	// advance the control words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
		end else begin
			ctrl_s1 <= '{valid: start && !busy, action: item.action, last: item.last};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
		end
	end

	// capture operands
	always_ff @(posedge clk) begin
		for (int k = 0; k < TERMS; k++) begin
			opa_s1[k] <= opa_c[k];
			opb_s1[k] <= opb_c[k];
		end
		sub_s1 <= sub_c;
		sub_s2 <= sub_s1;
		sub_s3 <= sub_s2;
		sub_s4 <= sub_s3;
	end

	for (genvar k = 0; k < TERMS; k++) begin : g_mul
		fdco_mul u_mul (
			.clk (clk),
			.a   (opa_s1[k]),
			.b   (opb_s1[k]),
			.p   (prod_s4[k])
		);
	end

	// pair the products, then sum the pairs, then round and form the norm sum
	always_ff @(posedge clk) begin
		ra_s5 <= sub_s4[0] ? SUM_W'(prod_s4[0]) - SUM_W'(prod_s4[1])
			: SUM_W'(prod_s4[0]) + SUM_W'(prod_s4[1]);
		rb_s5 <= sub_s4[1] ? SUM_W'(prod_s4[2]) - SUM_W'(prod_s4[3])
			: SUM_W'(prod_s4[2]) + SUM_W'(prod_s4[3]);
		ia_s5 <= sub_s4[2] ? SUM_W'(prod_s4[4]) - SUM_W'(prod_s4[5])
			: SUM_W'(prod_s4[4]) + SUM_W'(prod_s4[5]);
		ib_s5 <= sub_s4[3] ? SUM_W'(prod_s4[6]) - SUM_W'(prod_s4[7])
			: SUM_W'(prod_s4[6]) + SUM_W'(prod_s4[7]);
		re_s6 <= ra_s5 + rb_s5;
		im_s6 <= ia_s5 + ib_s5;
		re_s7 <= re_s6 + HALF;
		im_s7 <= im_s6 + HALF;
		n_s7  <= re_s6 + im_s6;
	end

	// saturate the product results per action
	assign re_sat = round_sat(re_s7);
	assign im_sat = round_sat(im_s7);

	always_comb begin
		side_c = '0;
		case (ctrl_s7.action)
			ACT_MUL, ACT_MUL_CONJ, ACT_SCALE_BY_REAL, ACT_SUM_MUL_CONJ: begin
				side_c.re  = re_sat[WORD_W-1:0];
				side_c.im  = im_sat[WORD_W-1:0];
				side_c.ovf = re_sat[WORD_W] | im_sat[WORD_W];
			end
			ACT_SELF_NORM: begin
				side_c.re  = re_sat[WORD_W-1:0];
				side_c.ovf = re_sat[WORD_W];
			end
			default: begin
				side_c = '0;
			end
		endcase
	end

	fdco_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_s7),
		.n_in     (n_s7),
		.side_in  (side_c),
		.ctrl_out (ctrl_dv),
		.side_out (side_dv),
		.quot     (quot_dv),
		.quot_ovf (qovf_dv),
		.dz       (dz_dv)
	);

	// pick the reciprocal or the carried result
	always_comb begin
		res_c.res_re   = side_dv.re;
		res_c.res_im   = side_dv.im;
		res_c.overflow = side_dv.ovf;
		res_c.div_zero = 1'b0;
		res_c.last_out = ctrl_dv.last;
		if (ctrl_dv.action == ACT_INV_NORM_SUM) begin
			res_c.res_im = '0;
			if (dz_dv) begin
				res_c.res_re   = RES_MAX;
				res_c.overflow = 1'b0;
				res_c.div_zero = 1'b1;
			end else if (qovf_dv) begin
				res_c.res_re   = RES_MAX;
				res_c.overflow = 1'b1;
			end else begin
				res_c.res_re   = $signed({1'b0, quot_dv});
				res_c.overflow = 1'b0;
			end
		end
	end

	// hold the result word for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

	// every accepted word gives a result after the fixed latency
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word gave no result");

	// no result without an accepted word
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result without accepted word");

	// a zero divisor never also flags saturation
	a_dz_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.div_zero |-> !result.overflow)
		else $error("div_zero with overflow");

	// a zero divisor gives the largest value and no imaginary part
	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.div_zero |-> result.res_re == RES_MAX && result.res_im == '0)
		else $error("bad div_zero result");

endmodule
